// File: src/assert_macros.svh
// Assertion macros for the RTL files, included by rate_weighted_process_pick.
// Each macro samples on the rising edge of clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Plain condition that must hold on every clock edge outside reset
`define ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

`endif

// File: src/rwpp_pkg.sv
// ----------------------------------------------------------------------------
// Rate-weighted pick package
// Shared types and fixed field widths for the rate-weighted process pick block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rwpp_pkg;

    localparam int RATE_W  = 32;
    localparam int SITES_W = 16;
    localparam int FRAC_W  = 32;
    localparam int IDX_W   = 8;
    localparam int COUNT_W = 9;

    localparam logic [COUNT_W-1:0] COUNT_RESET = 9'd256;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_PICK  = 1'b1;

    // One table entry as held in the memory
    typedef struct packed {
        logic [RATE_W-1:0]  rate;
        logic [SITES_W-1:0] sites;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WR_UPD,
        ST_PK_DRAW,
        ST_PK_WALK,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

// File: src/rate_weighted_process_pick.sv
// ----------------------------------------------------------------------------
// Rate-weighted process pick
// Keeps per-process rates and site counts in a RAM with a running total, and
// picks the first entry whose cumulative rate reaches a scaled random draw.
// ----------------------------------------------------------------------------
// A write reads the old entry, then writes the new one and adjusts the total.
// A pick scales the random fraction by the total, walks up to N entries with
// one RAM read each, N = min(count_reg, MAX_PROCESSES), and loads the result.
// Only one item is taken at a time: in_stall is high until the block is idle.
// Reset: a clearing pass writes zero to all MAX_PROCESSES entries, one per
// cycle, while no item is taken; configuration writes are taken throughout.
`timescale 1ns / 1ps
`default_nettype none

module rate_weighted_process_pick #(
    parameter int MAX_PROCESSES = 256
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [rwpp_pkg::COUNT_W-1:0]  cfg_wdata,
    input  wire logic                          in_valid,
    output      logic                          in_stall,
    input  wire logic                          operation,
    input  wire logic [rwpp_pkg::IDX_W-1:0]    process_index,
    input  wire logic [rwpp_pkg::RATE_W-1:0]   rate_value,
    input  wire logic [rwpp_pkg::SITES_W-1:0]  site_count,
    input  wire logic [rwpp_pkg::FRAC_W-1:0]   random_fraction,
    output      logic                          out_valid,
    input  wire logic                          out_stall,
    output      logic [rwpp_pkg::IDX_W-1:0]    picked_index,
    output      logic                          none_found
);

    import rwpp_pkg::*;

`include "assert_macros.svh"

    localparam int AW    = $clog2(MAX_PROCESSES);
    localparam int LW    = AW + 1;
    localparam int TW    = RATE_W + AW;
    localparam int CMPW  = (LW > COUNT_W) ? LW : COUNT_W;
    localparam int IDXCW = ((AW > IDX_W) ? AW : IDX_W) + 1;

    state_t               state_reg, state_next;
    logic [AW-1:0]        clr_cnt_reg, clr_cnt_next;
    logic [TW-1:0]        total_reg, total_next;
    logic [COUNT_W-1:0]   count_reg;
    logic                 out_valid_reg, out_valid_next;
    logic                 rsp_vld_reg, rsp_vld_next;

    logic [AW-1:0]        wr_addr_reg, wr_addr_next;
    entry_t               wr_entry_reg, wr_entry_next;
    logic [LW-1:0]        limit_reg, limit_next;
    logic [LW-1:0]        rd_cnt_reg, rd_cnt_next;
    logic [AW-1:0]        rsp_idx_reg, rsp_idx_next;
    logic                 rsp_last_reg, rsp_last_next;
    logic [TW-1:0]        cum_reg, cum_next;
    logic [AW-1:0]        res_idx_reg, res_idx_next;
    logic                 res_none_reg, res_none_next;
    logic [IDX_W-1:0]     picked_reg;
    logic                 none_reg;

    logic                 in_accept;
    logic                 idx_ok;
    logic [CMPW-1:0]      count_ext;
    logic [CMPW-1:0]      limit_sat;
    logic [TW-1:0]        cum_sum;
    logic                 finish;
    logic                 out_load;

    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    entry_t               ram_wdata;
    logic                 ram_re;
    logic [AW-1:0]        ram_raddr;
    entry_t               ram_rdata;

    logic                 draw_start;
    logic                 draw_done;
    logic [TW-1:0]        draw;

    // Entry table
    rwpp_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_PROCESSES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Scale the random fraction by the running total
    rwpp_draw #(
        .TOTAL_W (TW)
    ) u_draw (
        .clk   (clk),
        .rst_n (rst_n),
        .start (draw_start),
        .frac  (random_fraction),
        .total (total_reg),
        .done  (draw_done),
        .draw  (draw)
    );

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign idx_ok    = IDXCW'(process_index) < IDXCW'(MAX_PROCESSES);
    assign count_ext = CMPW'(count_reg);
    assign limit_sat = (count_ext > CMPW'(MAX_PROCESSES)) ? CMPW'(MAX_PROCESSES) : count_ext;

    // Next state, memory access and datapath control
    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        total_next     = total_reg;
        wr_addr_next   = wr_addr_reg;
        wr_entry_next  = wr_entry_reg;
        limit_next     = limit_reg;
        rd_cnt_next    = rd_cnt_reg;
        rsp_vld_next   = 1'b0;
        rsp_idx_next   = rsp_idx_reg;
        rsp_last_next  = rsp_last_reg;
        cum_next       = cum_reg;
        res_idx_next   = res_idx_reg;
        res_none_next  = res_none_reg;
        cum_sum        = cum_reg + TW'(ram_rdata.rate);
        finish         = 1'b0;
        out_load       = 1'b0;
        ram_we         = 1'b0;
        ram_waddr      = clr_cnt_reg;
        ram_wdata      = '0;
        ram_re         = 1'b0;
        ram_raddr      = rd_cnt_reg[AW-1:0];
        draw_start     = 1'b0;

        case (state_reg)
            ST_CLEAR:
            begin
                // Sweep zeros through the table
                ram_we = 1'b1;
                if (clr_cnt_reg == AW'(MAX_PROCESSES - 1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + 1'b1;
                end
            end

            ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (operation == OP_WRITE)
                    begin
                        // Fetch the old entry; drop writes beyond the table
                        if (idx_ok)
                        begin
                            ram_re        = 1'b1;
                            ram_raddr     = AW'(process_index);
                            wr_addr_next  = AW'(process_index);
                            wr_entry_next = '{rate: rate_value, sites: site_count};
                            state_next    = ST_WR_UPD;
                        end
                    end
                    else
                    begin
                        draw_start = 1'b1;
                        limit_next = LW'(limit_sat);
                        state_next = ST_PK_DRAW;
                    end
                end
            end

            ST_WR_UPD:
            begin
                // Write back and swap the old rate for the new one in the total
                ram_we     = 1'b1;
                ram_waddr  = wr_addr_reg;
                ram_wdata  = wr_entry_reg;
                total_next = total_reg - TW'(ram_rdata.rate) + TW'(wr_entry_reg.rate);
                state_next = ST_IDLE;
            end

            ST_PK_DRAW:
            begin
                if (draw_done)
                begin
                    rd_cnt_next   = '0;
                    cum_next      = '0;
                    res_idx_next  = '0;
                    res_none_next = 1'b1;
                    state_next    = (limit_reg == '0) ? ST_DONE : ST_PK_WALK;
                end
            end

            ST_PK_WALK:
            begin
                // Check the entry that came back from the RAM
                if (rsp_vld_reg)
                begin
                    cum_next = cum_sum;
                    if ((cum_sum >= draw) && (ram_rdata.sites != '0))
                    begin
                        res_idx_next  = rsp_idx_reg;
                        res_none_next = 1'b0;
                        finish        = 1'b1;
                    end
                    else if (rsp_last_reg)
                    begin
                        finish = 1'b1;
                    end
                end
                // Issue the next read while entries remain
                if (finish)
                begin
                    state_next = ST_DONE;
                end
                else if (rd_cnt_reg < limit_reg)
                begin
                    ram_re        = 1'b1;
                    rd_cnt_next   = rd_cnt_reg + 1'b1;
                    rsp_vld_next  = 1'b1;
                    rsp_idx_next  = rd_cnt_reg[AW-1:0];
                    rsp_last_next = (rd_cnt_reg == limit_reg - 1'b1);
                end
            end

            ST_DONE:
            begin
                // Hand the result to the output register once it is free
                if (!out_valid_reg || !out_stall)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg   <= '0;
            total_reg     <= '0;
            count_reg     <= COUNT_RESET;
            out_valid_reg <= 1'b0;
            rsp_vld_reg   <= 1'b0;
        end
        else
        begin
            clr_cnt_reg   <= clr_cnt_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
            rsp_vld_reg   <= rsp_vld_next;
            if (cfg_we)
            begin
                count_reg <= cfg_wdata;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        wr_addr_reg  <= wr_addr_next;
        wr_entry_reg <= wr_entry_next;
        limit_reg    <= limit_next;
        rd_cnt_reg   <= rd_cnt_next;
        rsp_idx_reg  <= rsp_idx_next;
        rsp_last_reg <= rsp_last_next;
        cum_reg      <= cum_next;
        res_idx_reg  <= res_idx_next;
        res_none_reg <= res_none_next;
        if (out_load)
        begin
            picked_reg <= res_none_reg ? '0 : IDX_W'(res_idx_reg);
            none_reg   <= res_none_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign picked_index = picked_reg;
    assign none_found   = none_reg;

    // Checks on the walk and the table access
    `ASSERT_IMPL(a_walk_no_write, state_reg == ST_PK_WALK, !ram_we,
        "table written during a pick walk")
    `ASSERT_IMPL(a_rsp_in_walk, rsp_vld_reg, state_reg == ST_PK_WALK,
        "read response pending outside the walk")
    `ASSERT_IMPL(a_draw_in_wait, draw_done, state_reg == ST_PK_DRAW,
        "draw finished while not waiting for it")
    `ASSERT_IMPL(a_cum_bounded, state_reg == ST_PK_WALK, cum_reg <= total_reg,
        "cumulative rate exceeds the running total")

endmodule

`default_nettype wire

// File: src/rwpp_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rwpp_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write, then register the read word
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// File: src/rwpp_draw.sv
// ----------------------------------------------------------------------------
// Draw scaler
// Forms (fraction * total) >> 32 exactly in two stages: two partial products,
// then their aligned sum. The result holds until the next start.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rwpp_draw #(
    parameter int TOTAL_W = 40
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [rwpp_pkg::FRAC_W-1:0] frac,
    input  wire logic [TOTAL_W-1:0]          total,
    output      logic                        done,
    output      logic [TOTAL_W-1:0]          draw
);

    import rwpp_pkg::*;

    logic                    s1_vld_reg;
    logic                    done_reg;
    logic [63:0]             p_lo_reg;
    logic [TOTAL_W-1:0]      p_hi_reg;
    logic [TOTAL_W-1:0]      draw_reg;
    logic [TOTAL_W-1:0]      draw_next;

    // Align the low product under the high one
    assign draw_next = p_hi_reg + TOTAL_W'(p_lo_reg[63:32]);

    // Track the beat through both stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= start;
            done_reg   <= s1_vld_reg;
        end
    end

    // Partial products, then the sum
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            p_lo_reg <= 64'(frac) * 64'(total[31:0]);
            p_hi_reg <= TOTAL_W'(frac) * TOTAL_W'(total[TOTAL_W-1:32]);
        end
        if (s1_vld_reg)
        begin
            draw_reg <= draw_next;
        end
    end

    assign done = done_reg;
    assign draw = draw_reg;

endmodule

`default_nettype wire
